[rtl/core/lav_pkg.sv]
// -----------------------------------------------------------------------------
// lav_pkg
// Shared widths, types and rounding helper for the look-at view matrix core.
// -----------------------------------------------------------------------------
package lav_pkg;

   localparam int FRAC_BITS = 16;                  // fraction bits of all fixed values
   localparam int IN_W      = 32;                  // port value width
   localparam int VEC_W     = FRAC_BITS + 34;      // signed vector width into normalizer
   localparam int MAG_W     = VEC_W;               // magnitude width
   localparam int NRM_W     = 30;                  // normalized magnitude, top in [2^29,2^30)
   localparam int SQ_W      = 2 * NRM_W + 2;       // sum of squares width
   localparam int ROOT_STEPS = SQ_W / 2;           // one root bit per stage
   localparam int LEN_W     = NRM_W + 1;           // root width
   localparam int QUO_W     = FRAC_BITS + 1;       // unit magnitude is at most 1.0
   localparam int UNIT_W    = QUO_W + 1;           // signed unit component
   localparam int NUM_W     = NRM_W + FRAC_BITS + 1; // dividend width
   localparam int GRP       = 8;                   // leading-one search group
   localparam int NGRP      = (MAG_W + GRP - 1) / GRP;
   localparam int POS_W     = $clog2(NGRP * GRP);
   localparam int WIDE_W    = 2 * IN_W + 4;        // dot products and crosses before rounding

   typedef logic signed [IN_W-1:0]   fix_type;
   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [UNIT_W-1:0] unit_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam fix_type FIX_MAX = 32'sh7FFF_FFFF;
   localparam fix_type FIX_MIN = 32'sh8000_0000;
   localparam fix_type FIX_ONE = fix_type'(1 << FRAC_BITS);

   typedef enum logic [1:0] {
      COL_X = 2'd0,
      COL_Y = 2'd1,
      COL_Z = 2'd2,
      COL_T = 2'd3
   } col_type;

   // data riding alongside a vector through the normalizer
   typedef struct packed {
      fix_type  [2:0] eye;
      fix_type  [2:0] up;
      unit_type [2:0] f;
      logic           ok;
   } side_type;

   // finished basis and translation terms
   typedef struct packed {
      unit_type [2:0] s;
      unit_type [2:0] f;
      fix_type  [2:0] u;
      fix_type  [2:0] t;
      logic           ok;
   } mat_type;

   // shift right by FRAC_BITS rounding half away from zero, then clamp to 32 bits
   function automatic fix_type rnd_sat(input wide_type v);
      logic [WIDE_W-1:0] m;
      wide_type          r;
      fix_type           o;
      m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
      m = (m + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      r = v[WIDE_W-1] ? -wide_type'(m) : wide_type'(m);
      if (r > wide_type'(FIX_MAX)) begin
         o = FIX_MAX;
      end else if (r < wide_type'(FIX_MIN)) begin
         o = FIX_MIN;
      end else begin
         o = r[IN_W-1:0];
      end
      return o;
   endfunction

endpackage

[rtl/core/lav_norm.sv]
// -----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale, squares, bit-per-stage root,
// bit-per-stage division of each component by the length.
// -----------------------------------------------------------------------------
module lav_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  lav_pkg::vec_type    in_vec [3],
   input  lav_pkg::side_type   in_side,
   output logic                out_valid,
   output lav_pkg::unit_type   out_unit [3],
   output lav_pkg::side_type   out_side
);

   localparam int MAG_W  = lav_pkg::MAG_W;
   localparam int NRM_W  = lav_pkg::NRM_W;
   localparam int SQ_W   = lav_pkg::SQ_W;
   localparam int STEPS  = lav_pkg::ROOT_STEPS;
   localparam int LEN_W  = lav_pkg::LEN_W;
   localparam int QUO_W  = lav_pkg::QUO_W;
   localparam int NUM_W  = lav_pkg::NUM_W;
   localparam int GRP    = lav_pkg::GRP;
   localparam int NGRP   = lav_pkg::NGRP;
   localparam int POS_W  = lav_pkg::POS_W;
   localparam int VEC_W  = lav_pkg::VEC_W;

   typedef struct packed {
      logic [SQ_W-1:0]            x;
      logic [SQ_W-1:0]            r;
      logic [2:0][NRM_W-1:0]      m;
      logic [2:0]                 neg;
      logic                       zero;
      lav_pkg::side_type          side;
   } rt_type;

   typedef struct packed {
      logic [2:0][NUM_W-1:0]      rem;
      logic [2:0][QUO_W-1:0]      q;
      logic [LEN_W-1:0]           len;
      logic [2:0]                 neg;
      logic                       zero;
      lav_pkg::side_type          side;
   } dv_type;

   // stage A: magnitudes
   logic                       va_ff;
   logic [MAG_W-1:0]           maga_ff [3];
   logic [2:0]                 nega_ff;
   lav_pkg::side_type          sidea_ff;
   // stage B: group flags
   logic                       vb_ff;
   logic [MAG_W-1:0]           magb_ff [3];
   logic [2:0]                 negb_ff;
   lav_pkg::side_type          sideb_ff;
   logic [NGRP-1:0]            nzb_ff;
   logic [2:0]                 posb_ff [NGRP];
   // stage C: leading one
   logic                       vc_ff;
   logic [MAG_W-1:0]           magc_ff [3];
   logic [2:0]                 negc_ff;
   lav_pkg::side_type          sidec_ff;
   logic [POS_W-1:0]           posc_ff;
   logic                       zeroc_ff;
   // stage D: scaled
   logic                       vd_ff;
   logic [NRM_W-1:0]           md_ff [3];
   logic [2:0]                 negd_ff;
   lav_pkg::side_type          sided_ff;
   logic                       zerod_ff;
   // stage E: squares
   logic                       ve_ff;
   logic [NRM_W-1:0]           me_ff [3];
   logic [2*NRM_W-1:0]         sqe_ff [3];
   logic [2:0]                 nege_ff;
   lav_pkg::side_type          sidee_ff;
   logic                       zeroe_ff;

   rt_type                     rt_ff [STEPS+1];
   rt_type                     rt_in [STEPS];
   logic                       rv_ff [STEPS+1];
   dv_type                     dv_ff [QUO_W+1];
   dv_type                     dv_in [QUO_W];
   logic                       dvv_ff [QUO_W+1];

   logic                       vo_ff;
   lav_pkg::unit_type          unit_ff [3];
   lav_pkg::side_type          side_ff;
   lav_pkg::side_type          side_in;

   logic [NGRP*GRP-1:0]        orw;
   logic                       nzb_in [NGRP];
   logic [2:0]                 posb_in [NGRP];
   logic [POS_W-1:0]           posc_in;
   logic                       zeroc_in;
   logic [MAG_W-1:0]           shd_in [3];

   // group flags of the OR of all magnitudes; its leading one is the top's
   always_comb begin
      orw = (NGRP*GRP)'(maga_ff[0] | maga_ff[1] | maga_ff[2]);
      for (int g = 0; g < NGRP; g++) begin
         nzb_in[g]  = |orw[g*GRP +: GRP];
         posb_in[g] = 3'd0;
         for (int b = 0; b < GRP; b++) begin
            if (orw[g*GRP + b]) begin
               posb_in[g] = 3'(b);
            end
         end
      end
   end

   always_comb begin
      posc_in  = '0;
      zeroc_in = 1'b1;
      for (int g = 0; g < NGRP; g++) begin
         if (nzb_ff[g]) begin
            posc_in  = POS_W'(g * GRP) + POS_W'(posb_ff[g]);
            zeroc_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (posc_ff >= POS_W'(NRM_W - 1)) begin
            shd_in[i] = magc_ff[i] >> (posc_ff - POS_W'(NRM_W - 1));
         end else begin
            shd_in[i] = magc_ff[i] << (POS_W'(NRM_W - 1) - posc_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         rv_ff[0] <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         rv_ff[0] <= ve_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            maga_ff[i] <= in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
            nega_ff[i] <= in_vec[i][VEC_W-1];
            magb_ff[i] <= maga_ff[i];
            magc_ff[i] <= magb_ff[i];
            md_ff[i]   <= shd_in[i][NRM_W-1:0];
            me_ff[i]   <= md_ff[i];
            sqe_ff[i]  <= md_ff[i] * md_ff[i];
         end
         for (int g = 0; g < NGRP; g++) begin
            nzb_ff[g]  <= nzb_in[g];
            posb_ff[g] <= posb_in[g];
         end
         sidea_ff <= in_side;
         negb_ff  <= nega_ff;
         sideb_ff <= sidea_ff;
         negc_ff  <= negb_ff;
         sidec_ff <= sideb_ff;
         posc_ff  <= posc_in;
         zeroc_ff <= zeroc_in;
         negd_ff  <= negc_ff;
         sided_ff <= sidec_ff;
         zerod_ff <= zeroc_ff;
         nege_ff  <= negd_ff;
         sidee_ff <= sided_ff;
         zeroe_ff <= zerod_ff;
         rt_ff[0].x    <= SQ_W'(sqe_ff[0]) + SQ_W'(sqe_ff[1]) + SQ_W'(sqe_ff[2]);
         rt_ff[0].r    <= '0;
         rt_ff[0].m    <= {me_ff[2], me_ff[1], me_ff[0]};
         rt_ff[0].neg  <= nege_ff;
         rt_ff[0].zero <= zeroe_ff;
         rt_ff[0].side <= sidee_ff;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_root
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2*k);
      logic [SQ_W-1:0] trial;
      always_comb begin
         trial    = rt_ff[k].r + BIT;
         rt_in[k] = rt_ff[k];
         if (rt_ff[k].x >= trial) begin
            rt_in[k].x = rt_ff[k].x - trial;
            rt_in[k].r = (rt_ff[k].r >> 1) + BIT;
         end else begin
            rt_in[k].r = rt_ff[k].r >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            rv_ff[k+1] <= rv_ff[k];
         end
         if (adv) begin
            rt_ff[k+1] <= rt_in[k];
         end
      end
   end

   // dividend with half the divisor added for rounding
   always_ff @(posedge clock) begin
      if (reset) begin
         dvv_ff[0] <= 1'b0;
      end else if (adv) begin
         dvv_ff[0] <= rv_ff[STEPS];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dv_ff[0].rem[i] <= (NUM_W'(rt_ff[STEPS].m[i]) << lav_pkg::FRAC_BITS)
                             + NUM_W'(rt_ff[STEPS].r[LEN_W-1:1]);
         end
         dv_ff[0].q    <= '0;
         dv_ff[0].len  <= rt_ff[STEPS].r[LEN_W-1:0];
         dv_ff[0].neg  <= rt_ff[STEPS].neg;
         dv_ff[0].zero <= rt_ff[STEPS].zero;
         dv_ff[0].side <= rt_ff[STEPS].side;
      end
   end

   // restoring division, one quotient bit per stage, three lanes
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int SH = QUO_W - 1 - j;
      logic [NUM_W-1:0] dvs;
      always_comb begin
         dvs      = NUM_W'(dv_ff[j].len) << SH;
         dv_in[j] = dv_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (dv_ff[j].rem[i] >= dvs) begin
               dv_in[j].rem[i]    = dv_ff[j].rem[i] - dvs;
               dv_in[j].q[i][SH]  = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dvv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dvv_ff[j+1] <= dvv_ff[j];
         end
         if (adv) begin
            dv_ff[j+1] <= dv_in[j];
         end
      end
   end

   // zero-length vector clears ok
   always_comb begin
      side_in    = dv_ff[QUO_W].side;
      side_in.ok = dv_ff[QUO_W].side.ok & ~dv_ff[QUO_W].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= dvv_ff[QUO_W];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            unit_ff[i] <= dv_ff[QUO_W].neg[i]
                        ? -lav_pkg::unit_type'({1'b0, dv_ff[QUO_W].q[i]})
                        :  lav_pkg::unit_type'({1'b0, dv_ff[QUO_W].q[i]});
         end
         side_ff <= side_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_unit  = unit_ff;
   assign out_side  = side_ff;

endmodule

[rtl/core/lav_cross.sv]
// -----------------------------------------------------------------------------
// lav_cross
// Exact cross product of the unit forward vector with the up hint.
// -----------------------------------------------------------------------------
module lav_cross (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  lav_pkg::unit_type   in_f [3],
   input  lav_pkg::side_type   in_side,
   output logic                out_valid,
   output lav_pkg::vec_type    out_vec [3],
   output lav_pkg::side_type   out_side
);

   logic                 v1_ff;
   lav_pkg::vec_type     p_ff [6];
   lav_pkg::side_type    side1_ff;
   lav_pkg::side_type    side1_in;
   logic                 v2_ff;
   lav_pkg::vec_type     c_ff [3];
   lav_pkg::side_type    side2_ff;

   // forward vector rides on with the side data
   always_comb begin
      side1_in   = in_side;
      side1_in.f = {in_f[2], in_f[1], in_f[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         p_ff[0] <= in_f[1] * in_side.up[2];
         p_ff[1] <= in_f[2] * in_side.up[1];
         p_ff[2] <= in_f[2] * in_side.up[0];
         p_ff[3] <= in_f[0] * in_side.up[2];
         p_ff[4] <= in_f[0] * in_side.up[1];
         p_ff[5] <= in_f[1] * in_side.up[0];
         side1_ff <= side1_in;
         c_ff[0]  <= p_ff[0] - p_ff[1];
         c_ff[1]  <= p_ff[2] - p_ff[3];
         c_ff[2]  <= p_ff[4] - p_ff[5];
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_vec   = c_ff;
   assign out_side  = side2_ff;

endmodule

[rtl/core/lav_basis.sv]
// -----------------------------------------------------------------------------
// lav_basis
// True up vector u = s x f and the three translation dot products.
// -----------------------------------------------------------------------------
module lav_basis (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  lav_pkg::unit_type   in_s [3],
   input  lav_pkg::side_type   in_side,
   output logic                out_valid,
   output lav_pkg::mat_type    out_mat
);

   localparam int WIDE_W = lav_pkg::WIDE_W;
   localparam int PSF_W  = 2 * lav_pkg::UNIT_W;
   localparam int PSE_W  = lav_pkg::UNIT_W + lav_pkg::IN_W;
   localparam int PUE_W  = 2 * lav_pkg::IN_W;

   logic [6:1]                  v_ff;
   lav_pkg::mat_type            m_ff [6:1];
   lav_pkg::mat_type            m3_in;
   lav_pkg::mat_type            m6_in;
   lav_pkg::fix_type            eye_ff [3:1][3];
   logic signed [PSF_W-1:0]     sf_ff [6];
   logic signed [PSE_W-1:0]     se_ff [3];
   logic signed [PSE_W-1:0]     fe_ff [3];
   lav_pkg::wide_type           ucr_ff [3];
   lav_pkg::wide_type           sse_ff;
   lav_pkg::wide_type           sfe_ff;
   logic signed [PUE_W-1:0]     ue_ff [3];
   lav_pkg::wide_type           sue_ff;

   // rounded terms merged into the passing matrix
   always_comb begin
      m3_in = m_ff[2];
      for (int i = 0; i < 3; i++) begin
         m3_in.u[i] = lav_pkg::rnd_sat(ucr_ff[i]);
      end
      m3_in.t[0] = lav_pkg::rnd_sat(-sse_ff);
      m3_in.t[2] = lav_pkg::rnd_sat(sfe_ff);
      m6_in      = m_ff[5];
      m6_in.t[1] = lav_pkg::rnd_sat(sue_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:1], in_valid};
      end
      if (adv) begin
         // stage 1: products
         m_ff[1].s  <= {in_s[2], in_s[1], in_s[0]};
         m_ff[1].f  <= in_side.f;
         m_ff[1].u  <= '0;
         m_ff[1].t  <= '0;
         m_ff[1].ok <= in_side.ok;
         for (int i = 0; i < 3; i++) begin
            eye_ff[1][i] <= in_side.eye[i];
            se_ff[i]     <= in_s[i] * in_side.eye[i];
            fe_ff[i]     <= in_side.f[i] * in_side.eye[i];
         end
         sf_ff[0] <= in_s[1] * in_side.f[2];
         sf_ff[1] <= in_s[2] * in_side.f[1];
         sf_ff[2] <= in_s[2] * in_side.f[0];
         sf_ff[3] <= in_s[0] * in_side.f[2];
         sf_ff[4] <= in_s[0] * in_side.f[1];
         sf_ff[5] <= in_s[1] * in_side.f[0];
         // stage 2: differences and sums
         m_ff[2] <= m_ff[1];
         eye_ff[2] <= eye_ff[1];
         ucr_ff[0] <= WIDE_W'(sf_ff[0]) - WIDE_W'(sf_ff[1]);
         ucr_ff[1] <= WIDE_W'(sf_ff[2]) - WIDE_W'(sf_ff[3]);
         ucr_ff[2] <= WIDE_W'(sf_ff[4]) - WIDE_W'(sf_ff[5]);
         sse_ff <= WIDE_W'(se_ff[0]) + WIDE_W'(se_ff[1]) + WIDE_W'(se_ff[2]);
         sfe_ff <= WIDE_W'(fe_ff[0]) + WIDE_W'(fe_ff[1]) + WIDE_W'(fe_ff[2]);
         // stage 3: round u, first and third translation terms
         m_ff[3] <= m3_in;
         eye_ff[3] <= eye_ff[2];
         // stage 4: u times eye
         m_ff[4] <= m_ff[3];
         for (int i = 0; i < 3; i++) begin
            ue_ff[i] <= m_ff[3].u[i] * eye_ff[3][i];
         end
         // stage 5: sum
         m_ff[5] <= m_ff[4];
         sue_ff <= -(WIDE_W'(ue_ff[0]) + WIDE_W'(ue_ff[1]) + WIDE_W'(ue_ff[2]));
         // stage 6: second translation term
         m_ff[6] <= m6_in;
      end
   end

   assign out_valid = v_ff[6];
   assign out_mat   = m_ff[6];

endmodule

[rtl/core/look_at_view_matrix_core.sv]
// -----------------------------------------------------------------------------
// look_at_view_matrix_core
// Fixed-point look-at view matrix, emitted as four column beats per camera.
// -----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  req_      in    req_valid/req_stall  eye, target, upvec (x,y,z), Q16.16
//  rsp_      out   rsp_valid/rsp_stall  column_index, elem_row0..3, last_column,
//                                       degenerate
//
//  A request beat can enter every cycle while req_stall is low; each one yields
//  four response beats, so sustained throughput is set by the response port.
//  Reset is synchronous and clears only valid bits and the column counter.
//  rsp_stall freezes the whole pipeline when the output holder is busy and the
//  last stage holds a matrix; nothing is dropped or repeated.
// -----------------------------------------------------------------------------
module look_at_view_matrix_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_eye_x,
   input  logic signed [31:0]      req_eye_y,
   input  logic signed [31:0]      req_eye_z,
   input  logic signed [31:0]      req_target_x,
   input  logic signed [31:0]      req_target_y,
   input  logic signed [31:0]      req_target_z,
   input  logic signed [31:0]      req_upvec_x,
   input  logic signed [31:0]      req_upvec_y,
   input  logic signed [31:0]      req_upvec_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_column_index,
   output logic signed [31:0]      rsp_elem_row0,
   output logic signed [31:0]      rsp_elem_row1,
   output logic signed [31:0]      rsp_elem_row2,
   output logic signed [31:0]      rsp_elem_row3,
   output logic                    rsp_last_column,
   output logic                    rsp_degenerate
);

   localparam int VEC_W = lav_pkg::VEC_W;

   // pipeline advance: stops only when the last stage holds a matrix and the
   // output holder cannot free up this cycle
   logic                   adv;
   logic                   taken;
   logic                   ser_free;

   // input register and difference stage
   logic                   v0_ff;
   lav_pkg::fix_type       eye0_ff [3];
   lav_pkg::fix_type       tgt0_ff [3];
   lav_pkg::fix_type       up0_ff  [3];
   logic                   v1_ff;
   lav_pkg::vec_type       d1_ff   [3];
   lav_pkg::side_type      side1_ff;

   logic                   n1_valid;
   lav_pkg::unit_type      n1_unit [3];
   lav_pkg::side_type      n1_side;
   logic                   cr_valid;
   lav_pkg::vec_type       cr_vec [3];
   lav_pkg::side_type      cr_side;
   logic                   n2_valid;
   lav_pkg::unit_type      n2_unit [3];
   lav_pkg::side_type      n2_side;
   logic                   bas_valid;
   lav_pkg::mat_type       bas_mat;

   // output holder
   logic                   ser_valid_ff;
   lav_pkg::col_type       col_ff;
   lav_pkg::mat_type       mat_ff;
   lav_pkg::fix_type       row_out [4];

   assign taken     = ser_valid_ff & ~rsp_stall;
   assign ser_free  = ~ser_valid_ff | (taken & (col_ff == lav_pkg::COL_T));
   assign adv       = ~bas_valid | ser_free;
   assign req_stall = ~adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
      end
      if (adv) begin
         eye0_ff[0] <= req_eye_x;
         eye0_ff[1] <= req_eye_y;
         eye0_ff[2] <= req_eye_z;
         tgt0_ff[0] <= req_target_x;
         tgt0_ff[1] <= req_target_y;
         tgt0_ff[2] <= req_target_z;
         up0_ff[0]  <= req_upvec_x;
         up0_ff[1]  <= req_upvec_y;
         up0_ff[2]  <= req_upvec_z;
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= VEC_W'(tgt0_ff[i]) - VEC_W'(eye0_ff[i]);
         end
         side1_ff.eye <= {eye0_ff[2], eye0_ff[1], eye0_ff[0]};
         side1_ff.up  <= {up0_ff[2], up0_ff[1], up0_ff[0]};
         side1_ff.f   <= '0;
         side1_ff.ok  <= 1'b1;
      end
   end

   // forward vector
   lav_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v1_ff),
      .in_vec    (d1_ff),
      .in_side   (side1_ff),
      .out_valid (n1_valid),
      .out_unit  (n1_unit),
      .out_side  (n1_side)
   );

   lav_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (n1_valid),
      .in_f      (n1_unit),
      .in_side   (n1_side),
      .out_valid (cr_valid),
      .out_vec   (cr_vec),
      .out_side  (cr_side)
   );

   // right vector
   lav_norm u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cr_valid),
      .in_vec    (cr_vec),
      .in_side   (cr_side),
      .out_valid (n2_valid),
      .out_unit  (n2_unit),
      .out_side  (n2_side)
   );

   lav_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (n2_valid),
      .in_s      (n2_unit),
      .in_side   (n2_side),
      .out_valid (bas_valid),
      .out_mat   (bas_mat)
   );

   // holder walks the four columns, one beat each
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         col_ff       <= lav_pkg::COL_X;
      end else if (bas_valid && adv) begin
         ser_valid_ff <= 1'b1;
         col_ff       <= lav_pkg::COL_X;
      end else if (taken) begin
         if (col_ff == lav_pkg::COL_T) begin
            ser_valid_ff <= 1'b0;
         end
         col_ff <= lav_pkg::col_type'(col_ff + 2'd1);
      end
      if (bas_valid && adv) begin
         mat_ff <= bas_mat;
      end
   end

   always_comb begin
      case (col_ff)
         lav_pkg::COL_X: begin
            row_out[0] = lav_pkg::fix_type'(mat_ff.s[0]);
            row_out[1] = mat_ff.u[0];
            row_out[2] = -lav_pkg::fix_type'(mat_ff.f[0]);
            row_out[3] = '0;
         end
         lav_pkg::COL_Y: begin
            row_out[0] = lav_pkg::fix_type'(mat_ff.s[1]);
            row_out[1] = mat_ff.u[1];
            row_out[2] = -lav_pkg::fix_type'(mat_ff.f[1]);
            row_out[3] = '0;
         end
         lav_pkg::COL_Z: begin
            row_out[0] = lav_pkg::fix_type'(mat_ff.s[2]);
            row_out[1] = mat_ff.u[2];
            row_out[2] = -lav_pkg::fix_type'(mat_ff.f[2]);
            row_out[3] = '0;
         end
         default: begin
            row_out[0] = mat_ff.t[0];
            row_out[1] = mat_ff.t[1];
            row_out[2] = mat_ff.t[2];
            row_out[3] = lav_pkg::FIX_ONE;
         end
      endcase
      // degenerate camera: every element reads zero
      if (!mat_ff.ok) begin
         for (int r = 0; r < 4; r++) begin
            row_out[r] = '0;
         end
      end
   end

   assign rsp_valid        = ser_valid_ff;
   assign rsp_column_index = col_ff;
   assign rsp_elem_row0    = row_out[0];
   assign rsp_elem_row1    = row_out[1];
   assign rsp_elem_row2    = row_out[2];
   assign rsp_elem_row3    = row_out[3];
   assign rsp_last_column  = (col_ff == lav_pkg::COL_T);
   assign rsp_degenerate   = ~mat_ff.ok;

   // ---- assertions ----
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      (taken && col_ff != lav_pkg::COL_T) |=>
         (rsp_valid && rsp_column_index == $past(rsp_column_index) + 2'd1))
      else $error("column sequence broken");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output holder");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_elem_row0 == 0 && rsp_elem_row1 == 0 &&
          rsp_elem_row2 == 0 && rsp_elem_row3 == 0))
      else $error("degenerate beat carries nonzero data");

   a_row3_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_column) |-> (rsp_elem_row3 == 0))
      else $error("row 3 nonzero outside translation column");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point look-at view matrix core. Camera
// beats go in with random gaps; each accepted beat is run through a local
// model that predicts its four column beats, which are compared field by
// field as they leave the block under random output stalls.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int  MAX_CYCLES  = 600000;
   localparam int  DRAIN_WAIT  = 300;   // longer than the pipeline depth
   localparam int  RANDOM_ITEMS = 340;
   localparam longint ONE_Q = longint'(1) << lav_pkg::FRAC_BITS;

   // one column beat as the block should present it
   typedef struct {
      logic [1:0] idx;
      lav_pkg::fix_type row0, row1, row2, row3;
      logic       last, degen;
   } column_beat_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   lav_pkg::fix_type req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   lav_pkg::fix_type req_target_x = '0, req_target_y = '0, req_target_z = '0;
   lav_pkg::fix_type req_upvec_x = '0, req_upvec_y = '0, req_upvec_z = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   logic [1:0] rsp_column_index;
   lav_pkg::fix_type rsp_elem_row0, rsp_elem_row1, rsp_elem_row2, rsp_elem_row3;
   logic    rsp_last_column, rsp_degenerate;

   column_beat_type column_q[$];   // predicted beats not yet seen
   int  error_count = 0;
   int  cycle_count = 0;
   bit  quiet = 1'b0;           // no idling on either side
   int  hold_req = 0;           // cycles of forced output stall requested

   look_at_view_matrix_core dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic longint unsigned mag_of(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint sat_fix(input longint v);
      if (v > longint'(lav_pkg::FIX_MAX)) return longint'(lav_pkg::FIX_MAX);
      if (v < longint'(lav_pkg::FIX_MIN)) return longint'(lav_pkg::FIX_MIN);
      return v;
   endfunction

   // drop FRAC_BITS, rounding half away from zero
   function automatic longint round_frac(input longint v);
      longint unsigned m;
      m = (mag_of(v) + (64'd1 << (lav_pkg::FRAC_BITS - 1))) >> lav_pkg::FRAC_BITS;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // scale to unit length; returns 0 when the vector has no length
   function automatic bit to_unit(input longint v[3], output longint u[3]);
      longint unsigned m[3], top, sum, len, q;
      top = 0;
      sum = 0;
      u = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
         m[i] = mag_of(v[i]);
         if (m[i] > top) top = m[i];
      end
      if (top == 0) return 1'b0;
      // bring the largest magnitude into [2^29, 2^30)
      while (top >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         top = top >> 1;
      end
      while (top < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         top = top << 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      if (len == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << lav_pkg::FRAC_BITS) + (len >> 1)) / len;
         u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic longint dot3(input longint a[3], input longint b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   task automatic predict_view(input lav_pkg::fix_type e[3], input lav_pkg::fix_type t[3],
                               input lav_pkg::fix_type up[3]);
      longint ev[3], uv[3], d[3], f[3], c[3], s[3], u[3];
      longint col[4][4];
      bit ok;
      column_beat_type b;
      for (int i = 0; i < 3; i++) begin
         ev[i] = e[i];
         uv[i] = up[i];
         d[i]  = longint'(t[i]) - longint'(e[i]);
      end
      for (int k = 0; k < 4; k++)
         for (int i = 0; i < 4; i++) col[k][i] = 0;
      ok = to_unit(d, f);
      if (ok) begin
         c[0] = f[1] * uv[2] - f[2] * uv[1];
         c[1] = f[2] * uv[0] - f[0] * uv[2];
         c[2] = f[0] * uv[1] - f[1] * uv[0];
         ok = to_unit(c, s);
      end
      if (ok) begin
         u[0] = sat_fix(round_frac(s[1] * f[2] - s[2] * f[1]));
         u[1] = sat_fix(round_frac(s[2] * f[0] - s[0] * f[2]));
         u[2] = sat_fix(round_frac(s[0] * f[1] - s[1] * f[0]));
         for (int k = 0; k < 3; k++) begin
            col[k][0] = s[k];
            col[k][1] = u[k];
            col[k][2] = -f[k];
         end
         col[3][0] = sat_fix(round_frac(-dot3(s, ev)));
         col[3][1] = sat_fix(round_frac(-dot3(u, ev)));
         col[3][2] = sat_fix(round_frac(dot3(f, ev)));
         col[3][3] = ONE_Q;
      end
      for (int k = 0; k < 4; k++) begin
         b.idx   = k[1:0];
         b.row0  = lav_pkg::fix_type'(col[k][0]);
         b.row1  = lav_pkg::fix_type'(col[k][1]);
         b.row2  = lav_pkg::fix_type'(col[k][2]);
         b.row3  = lav_pkg::fix_type'(col[k][3]);
         b.last  = (k[1:0] == lav_pkg::COL_T);
         b.degen = !ok;
         column_q.push_back(b);
      end
   endtask

   // ---------------------------------------------------------------- driving
   // Drive one camera beat and hold it until taken, then maybe idle a while.
   task automatic send_camera(input lav_pkg::fix_type e[3], input lav_pkg::fix_type t[3],
                              input lav_pkg::fix_type up[3]);
      req_valid    <= 1'b1;
      req_eye_x    <= e[0];  req_eye_y    <= e[1];  req_eye_z    <= e[2];
      req_target_x <= t[0];  req_target_y <= t[1];  req_target_z <= t[2];
      req_upvec_x  <= up[0]; req_upvec_y  <= up[1]; req_upvec_z  <= up[2];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_view(e, t, up);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (column_q.size() != 0) @(posedge clock);
   endtask

   // mixed-scale random value: full range, two narrower ranges or tiny
   function automatic lav_pkg::fix_type rand_fix();
      case ($urandom_range(0, 3))
         0: return lav_pkg::fix_type'($urandom);
         1: return lav_pkg::fix_type'($signed($urandom_range(0, 32'h00FF_FFFF))
                                      - 32'sh0080_0000);
         2: return lav_pkg::fix_type'($signed($urandom_range(0, 32'h3FFF_FFFF))
                                      - 32'sh2000_0000);
         default: return lav_pkg::fix_type'($signed($urandom_range(0, 255)) - 128);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_extremes();
      lav_pkg::fix_type e[3], t[3], up[3];
      e = '{lav_pkg::FIX_MIN, lav_pkg::FIX_MIN, lav_pkg::FIX_MIN};
      t = '{lav_pkg::FIX_MAX, lav_pkg::FIX_MAX, lav_pkg::FIX_MAX};
      up = '{lav_pkg::FIX_ONE, 0, 0};
      send_camera(e, t, up);
      e = '{lav_pkg::FIX_MAX, lav_pkg::FIX_MAX, lav_pkg::FIX_MAX};
      t = '{lav_pkg::FIX_MIN, lav_pkg::FIX_MIN, lav_pkg::FIX_MIN};
      up = '{lav_pkg::FIX_MIN, lav_pkg::FIX_MAX, lav_pkg::FIX_MIN};
      send_camera(e, t, up);
      e = '{lav_pkg::FIX_MAX, 0, 0}; t = '{lav_pkg::FIX_MAX, 0, lav_pkg::FIX_MIN};
      up = '{0, lav_pkg::FIX_MAX, 0};
      send_camera(e, t, up);
      // classic camera on +z looking at the origin
      e = '{0, 0, 5 * lav_pkg::FIX_ONE}; t = '{0, 0, 0}; up = '{0, lav_pkg::FIX_ONE, 0};
      send_camera(e, t, up);
      // translation saturates: unit axis times a huge eye
      e = '{lav_pkg::FIX_MAX, lav_pkg::FIX_MIN, lav_pkg::FIX_MAX};
      t = '{lav_pkg::FIX_MAX, lav_pkg::FIX_MIN, lav_pkg::FIX_MAX - 1};
      up = '{0, 1, 0};
      send_camera(e, t, up);
      e = '{lav_pkg::FIX_MIN, lav_pkg::FIX_MAX, lav_pkg::FIX_MIN};
      t = '{lav_pkg::FIX_MIN + 1, lav_pkg::FIX_MAX, lav_pkg::FIX_MIN};
      up = '{0, 0, -1};
      send_camera(e, t, up);
      // tiny forward vector, heavy left shift in the normalizer
      e = '{0, 0, 0}; t = '{1, -1, 1}; up = '{-1, 1, 1};
      send_camera(e, t, up);
      e = '{-1, -1, -1}; t = '{32'sh7FFF_0000, 3, -7};
      up = '{5, lav_pkg::FIX_MIN, lav_pkg::FIX_MAX};
      send_camera(e, t, up);
   endtask

   task automatic test_degenerate();
      lav_pkg::fix_type e[3], t[3], up[3];
      // target on the eye
      e = '{12345, -678, lav_pkg::FIX_ONE}; t = e; up = '{0, lav_pkg::FIX_ONE, 0};
      send_camera(e, t, up);
      e = '{lav_pkg::FIX_MIN, lav_pkg::FIX_MIN, lav_pkg::FIX_MIN}; t = e;
      up = '{lav_pkg::FIX_MAX, lav_pkg::FIX_MAX, lav_pkg::FIX_MAX};
      send_camera(e, t, up);
      // zero up hint
      e = '{0, 0, 0}; t = '{lav_pkg::FIX_ONE, 2 * lav_pkg::FIX_ONE, 3}; up = '{0, 0, 0};
      send_camera(e, t, up);
      // up parallel to forward on each axis
      e = '{0, 0, 0}; t = '{0, lav_pkg::FIX_ONE, 0}; up = '{0, 7, 0};
      send_camera(e, t, up);
      e = '{lav_pkg::FIX_ONE, 0, 0}; t = '{lav_pkg::FIX_MIN, 0, 0};
      up = '{lav_pkg::FIX_MAX, 0, 0};
      send_camera(e, t, up);
      e = '{0, 0, lav_pkg::FIX_MAX}; t = '{0, 0, lav_pkg::FIX_MIN}; up = '{0, 0, -3};
      send_camera(e, t, up);
   endtask

   task automatic random_camera();
      lav_pkg::fix_type e[3], t[3], up[3];
      for (int i = 0; i < 3; i++) begin
         e[i] = rand_fix(); t[i] = rand_fix(); up[i] = rand_fix();
      end
      case ($urandom_range(0, 19))
         0: t = e;                                   // no forward vector
         1: up = '{0, 0, 0};
         2: begin                                    // axis-parallel up
            int ax;
            ax = $urandom_range(0, 2);
            t = e;
            t[ax] = rand_fix();
            up = '{0, 0, 0};
            up[ax] = rand_fix();
         end
         default: ;
      endcase
      send_camera(e, t, up);
   endtask

   task automatic test_random(input int n);
      repeat (n) random_camera();
   endtask

   // output held off for a long stretch while requests keep coming
   task automatic test_backpressure();
      hold_req = 400;
      repeat (30) random_camera();
      drain_all();   // sender pauses until everything is out
   endtask

   // ---------------------------------------------------------------- output side
   initial begin
      int hold_left, burst_left;
      hold_left = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (burst_left != 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare every accepted column beat with the oldest prediction
   always @(posedge clock) begin
      column_beat_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (column_q.size() == 0) begin
            $error("column beat with nothing predicted: column %0d", rsp_column_index);
            error_count++;
         end else begin
            x = column_q.pop_front();
            if (rsp_column_index !== x.idx) begin
               $error("column_index expected %0d got %0d", x.idx, rsp_column_index);
               error_count++;
            end
            if (rsp_elem_row0 !== x.row0) begin
               $error("elem_row0 expected %h got %h", x.row0, rsp_elem_row0);
               error_count++;
            end
            if (rsp_elem_row1 !== x.row1) begin
               $error("elem_row1 expected %h got %h", x.row1, rsp_elem_row1);
               error_count++;
            end
            if (rsp_elem_row2 !== x.row2) begin
               $error("elem_row2 expected %h got %h", x.row2, rsp_elem_row2);
               error_count++;
            end
            if (rsp_elem_row3 !== x.row3) begin
               $error("elem_row3 expected %h got %h", x.row3, rsp_elem_row3);
               error_count++;
            end
            if (rsp_last_column !== x.last) begin
               $error("last_column expected %0b got %0b", x.last, rsp_last_column);
               error_count++;
            end
            if (rsp_degenerate !== x.degen) begin
               $error("degenerate expected %0b got %0b", x.degen, rsp_degenerate);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_degenerate();
      test_random(RANDOM_ITEMS / 2);
      test_backpressure();
      test_random(RANDOM_ITEMS / 2 - 40);
      quiet = 1'b1;      // final stretch at full rate, no idling
      test_random(40);
      drain_all();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && column_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/lav_pkg.sv
rtl/core/lav_norm.sv
rtl/core/lav_cross.sv
rtl/core/lav_basis.sv
rtl/core/look_at_view_matrix_core.sv
tb/tb_top.sv
